@@ hdl/pfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_pkg: shared types and constants for the postfix expression evaluator
// Character codes, status codes, state enums and the ALU request/response.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned DATA_W          = 32;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_CARET = 8'h5E;  // '^'

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_DIVZERO   = 2'd3
  } pfe_status_e;

  typedef enum logic [1:0] {
    ALU_OP_MUL = 2'd0,
    ALU_OP_DIV = 2'd1,
    ALU_OP_POW = 2'd2
  } pfe_alu_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_DECODE,
    S_READ_A,
    S_READ_B,
    S_EXEC,
    S_WAIT_ALU,
    S_EMIT
  } pfe_state_e;

  typedef enum logic [2:0] {
    ALU_IDLE,
    ALU_MUL,
    ALU_DIV,
    ALU_DFIX,
    ALU_POW_MUL,
    ALU_POW_SQR,
    ALU_DONE
  } pfe_alu_state_e;

  typedef struct packed {
    logic        start;
    pfe_alu_op_e op;
  } pfe_alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } pfe_alu_rsp_t;

endpackage

@@ hdl/postfix_expression_evaluator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator: byte-serial RPN integer evaluator
// Sequence: digits, and bytes skipped after an error, are taken in IDLE;
// others pass PUSH and DECODE, NUL results and errors wait in EMIT for the
// output; / runs 32 divider steps, ^ a multiply and a square per exponent bit.
// One byte at a time: the input is not ready while the sequencer is busy.
// Reset clears the stack depth, the number accumulator and the error state.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator import pfe_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] character
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] value
  output logic [1:0]        m_axis_tuser    // [1:0] status
);

  localparam int unsigned IdxW = $clog2(STACK_DEPTH);
  localparam int unsigned DepW = $clog2(STACK_DEPTH + 1);

  pfe_state_e        state_q, state_d;
  logic [7:0]        ch_q, ch_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic              in_num_q, in_num_d;
  logic              disc_q, disc_d;
  logic [DepW-1:0]   depth_q, depth_d;
  logic [DATA_W-1:0] a_q, a_d;
  logic [DATA_W-1:0] b_q, b_d;
  logic [DATA_W-1:0] res_val_q, res_val_d;
  pfe_status_e       res_st_q, res_st_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;
  pfe_status_e       out_status_q, out_status_d;

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata;

  pfe_alu_req_t      alu_req;
  pfe_alu_rsp_t      alu_rsp;
  pfe_alu_op_e       alu_op;

  logic              in_xfer, in_digit, is_nul, is_op, out_free;
  logic [DepW-1:0]   depth_m1, depth_m2;
  logic [7:0]        digit;

  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign in_digit = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
  assign digit    = s_axis_tdata - CH_ZERO;
  assign is_nul   = (ch_q == CH_NUL);
  assign is_op    = (ch_q == CH_PLUS) || (ch_q == CH_MINUS) || (ch_q == CH_STAR) ||
                    (ch_q == CH_SLASH) || (ch_q == CH_CARET);
  assign out_free = ~out_valid_q | m_axis_tready;
  assign depth_m1 = depth_q - DepW'(1);
  assign depth_m2 = depth_q - DepW'(2);

  always_comb begin
    priority if (ch_q == CH_STAR) begin
      alu_op = ALU_OP_MUL;
    end else if (ch_q == CH_SLASH) begin
      alu_op = ALU_OP_DIV;
    end else begin
      alu_op = ALU_OP_POW;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && !disc_q && !in_digit) state_d = S_PUSH;
      end
      S_PUSH: begin
        if (in_num_q && depth_q >= DepW'(STACK_DEPTH)) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (is_nul) begin
          state_d = (depth_q == '0) ? S_EMIT : S_READ_A;
        end else if (is_op) begin
          state_d = (depth_q < DepW'(2)) ? S_EMIT : S_READ_A;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_READ_A: state_d = is_nul ? S_EMIT : S_READ_B;
      S_READ_B: begin
        state_d = (ch_q == CH_SLASH && a_q == '0) ? S_EMIT : S_EXEC;
      end
      S_EXEC: begin
        state_d = (ch_q == CH_PLUS || ch_q == CH_MINUS) ? S_IDLE : S_WAIT_ALU;
      end
      S_WAIT_ALU: if (alu_rsp.done) state_d = S_IDLE;
      S_EMIT:     if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and control
  always_comb begin
    ch_d         = ch_q;
    acc_d        = acc_q;
    in_num_d     = in_num_q;
    disc_d       = disc_q;
    depth_d      = depth_q;
    a_d          = a_q;
    b_d          = b_q;
    res_val_d    = res_val_q;
    res_st_d     = res_st_q;
    out_valid_d  = out_valid_q & ~m_axis_tready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    mem_waddr    = depth_q[IdxW-1:0];
    mem_wdata    = acc_q;
    mem_re       = 1'b0;
    mem_raddr    = depth_m1[IdxW-1:0];
    alu_req      = '{start: 1'b0, op: alu_op};
    s_axis_tready = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_xfer) begin
          ch_d = s_axis_tdata;
          if (disc_q) begin
            if (s_axis_tdata == CH_NUL) disc_d = 1'b0;
          end else if (in_digit) begin
            acc_d    = {acc_q[DATA_W-4:0], 3'b000} + {acc_q[DATA_W-2:0], 1'b0} +
                       DATA_W'(digit[3:0]);
            in_num_d = 1'b1;
          end
        end
      end
      S_PUSH: begin
        if (in_num_q) begin
          if (depth_q >= DepW'(STACK_DEPTH)) begin
            depth_d   = '0;
            acc_d     = '0;
            in_num_d  = 1'b0;
            disc_d    = ~is_nul;
            res_val_d = '0;
            res_st_d  = STAT_OVERFLOW;
          end else begin
            mem_we   = 1'b1;
            depth_d  = depth_q + DepW'(1);
            acc_d    = '0;
            in_num_d = 1'b0;
          end
        end
      end
      S_DECODE: begin
        if (is_nul || is_op) begin
          if (depth_q == '0 || (is_op && depth_q < DepW'(2))) begin
            depth_d   = '0;
            disc_d    = ~is_nul;
            res_val_d = '0;
            res_st_d  = STAT_UNDERFLOW;
          end else begin
            mem_re = 1'b1;
          end
        end
      end
      S_READ_A: begin
        a_d = rdata_q;
        if (is_nul) begin
          res_val_d = rdata_q;
          res_st_d  = STAT_OK;
          depth_d   = '0;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = depth_m2[IdxW-1:0];
        end
      end
      S_READ_B: begin
        b_d = rdata_q;
        if (ch_q == CH_SLASH && a_q == '0) begin
          depth_d   = '0;
          disc_d    = 1'b1;
          res_val_d = '0;
          res_st_d  = STAT_DIVZERO;
        end
      end
      S_EXEC: begin
        if (ch_q == CH_PLUS || ch_q == CH_MINUS) begin
          mem_we    = 1'b1;
          mem_waddr = depth_m2[IdxW-1:0];
          mem_wdata = (ch_q == CH_PLUS) ? (b_q + a_q) : (b_q - a_q);
          depth_d   = depth_m1;
        end else begin
          alu_req.start = 1'b1;
        end
      end
      S_WAIT_ALU: begin
        if (alu_rsp.done) begin
          mem_we    = 1'b1;
          mem_waddr = depth_m2[IdxW-1:0];
          mem_wdata = alu_rsp.result;
          depth_d   = depth_m1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = res_val_q;
          out_status_d = res_st_q;
        end
      end
      default: ;
    endcase
  end

  pfe_alu u_pfe_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (a_q),
    .b_i    (b_q),
    .rsp_o  (alu_rsp)
  );

  // operand stack
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      in_num_q    <= 1'b0;
      disc_q      <= 1'b0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      in_num_q    <= in_num_d;
      disc_q      <= disc_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q         <= ch_d;
    a_q          <= a_d;
    b_q          <= b_d;
    res_val_q    <= res_val_d;
    res_st_q     <= res_st_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;

endmodule

@@ hdl/pfe_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_alu: iterative multiply / divide / power unit
// One 32x32 low-half multiplier shared by multiply and power, and a
// restoring divider stepping one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfe_alu import pfe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfe_alu_req_t      req_i,
  input  logic [DATA_W-1:0] a_i,    // top operand: multiplier, divisor, exponent
  input  logic [DATA_W-1:0] b_i,    // second operand: multiplicand, dividend, base
  output pfe_alu_rsp_t      rsp_o
);

  localparam int unsigned CntW = $clog2(DATA_W);

  pfe_alu_state_e    state_q, state_d;
  logic [DATA_W-1:0] x_q, x_d;
  logic [DATA_W-1:0] y_q, y_d;
  logic [DATA_W-1:0] r_q, r_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              neg_q, neg_d;

  logic [DATA_W-1:0] mul_a, mul_b, mul_lo;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W+1:0] diff;
  logic              ge;

  always_comb begin
    unique case (state_q)
      ALU_POW_MUL: begin
        mul_a = r_q;
        mul_b = x_q;
      end
      ALU_POW_SQR: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      default: begin
        mul_a = x_q;
        mul_b = y_q;
      end
    endcase
  end

  assign mul_lo = mul_a * mul_b;

  // restoring step: quotient bits shift into x_q as dividend bits leave it
  assign rem_sh = {rem_q, x_q[DATA_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, y_q};
  assign ge     = ~diff[DATA_W+1];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ALU_IDLE: begin
        if (req_i.start) begin
          priority case (req_i.op)
            ALU_OP_MUL: state_d = ALU_MUL;
            ALU_OP_DIV: state_d = ALU_DIV;
            ALU_OP_POW: state_d = a_i[DATA_W-1] ? ALU_DONE : ALU_POW_MUL;
            default:    state_d = ALU_IDLE;
          endcase
        end
      end
      ALU_MUL:     state_d = ALU_DONE;
      ALU_DIV:     if (cnt_q == CntW'(DATA_W - 1)) state_d = ALU_DFIX;
      ALU_DFIX:    state_d = ALU_DONE;
      ALU_POW_MUL: state_d = (y_q == '0) ? ALU_DONE : ALU_POW_SQR;
      ALU_POW_SQR: state_d = ALU_POW_MUL;
      ALU_DONE:    state_d = ALU_IDLE;
      default:     state_d = ALU_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    r_d   = r_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    unique case (state_q)
      ALU_IDLE: begin
        if (req_i.start) begin
          priority case (req_i.op)
            ALU_OP_MUL: begin
              x_d = b_i;
              y_d = a_i;
            end
            ALU_OP_DIV: begin
              x_d   = b_i[DATA_W-1] ? (~b_i + 1'b1) : b_i;
              y_d   = a_i[DATA_W-1] ? (~a_i + 1'b1) : a_i;
              neg_d = b_i[DATA_W-1] ^ a_i[DATA_W-1];
              rem_d = '0;
              cnt_d = '0;
            end
            ALU_OP_POW: begin
              x_d = b_i;
              y_d = a_i;
              if (a_i[DATA_W-1]) begin
                // negative exponent: only bases of one and minus one survive
                if (b_i == DATA_W'(1)) begin
                  r_d = DATA_W'(1);
                end else if (b_i == '1) begin
                  r_d = a_i[0] ? '1 : DATA_W'(1);
                end else begin
                  r_d = '0;
                end
              end else begin
                r_d = DATA_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ALU_MUL: r_d = mul_lo;
      ALU_DIV: begin
        rem_d = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        x_d   = {x_q[DATA_W-2:0], ge};
        cnt_d = cnt_q + 1'b1;
      end
      ALU_DFIX: r_d = neg_q ? (~x_q + 1'b1) : x_q;
      ALU_POW_MUL: begin
        if (y_q != '0 && y_q[0]) r_d = mul_lo;
      end
      ALU_POW_SQR: begin
        x_d = mul_lo;
        y_d = {1'b0, y_q[DATA_W-1:1]};
      end
      ALU_DONE: ;
      default: ;
    endcase
  end

  assign rsp_o.done   = (state_q == ALU_DONE);
  assign rsp_o.result = r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ALU_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    r_q   <= r_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

endmodule

@@ hdl/pfe_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_checker: port-level assertions for the postfix expression evaluator
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module pfe_checker import pfe_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata,
  input logic [1:0]        m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tdata == '0)
    else $error("error result with nonzero value");

  // a result is only loaded while the sequencer is busy, never from idle
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a busy cycle");

  // no result is offered once reset has been seen at an edge
  a_rst_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/sv/tb_postfix_expression_evaluator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_postfix_expression_evaluator: self-checking bench for the RPN evaluator
// Streams postfix text into the block byte by byte. A scoreboard keeps its own
// stack model and queues the value/status expected for each NUL or error.
// Output transfers are checked against that queue. Both stream sides idle at
// random. The receiver holds off once for a long stretch, and the sender
// drains once.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator;
  import pfe_pkg::*;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam int unsigned N_ITEMS  = 1200;
  localparam int unsigned HOLD_LEN = 400;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  bit          sender_burst  = 1'b0;
  bit          hold_req      = 1'b0;
  logic [7:0]  byte_q[$];

  typedef struct packed {
    logic [31:0] value;
    pfe_status_e status;
  } eval_result_t;

  class eval_scoreboard;
    logic [31:0]  operands[STACK_DEPTH_DEF];
    int unsigned  depth;
    logic [31:0]  accum;
    bit           in_digits;
    bit           skipping;
    eval_result_t expected_q[$];
    int           errors;

    function new();
      clear_expr();
      skipping = 1'b0;
      errors   = 0;
    endfunction

    function void clear_expr();
      depth     = 0;
      accum     = '0;
      in_digits = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [31:0] quotient(logic [31:0] num, logic [31:0] den);
      logic [31:0] mag_n;
      logic [31:0] mag_d;
      logic [31:0] q;
      mag_n = num[31] ? -num : num;
      mag_d = den[31] ? -den : den;
      q     = mag_n / mag_d;
      return (num[31] ^ den[31]) ? -q : q;
    endfunction

    function logic [31:0] power(logic [31:0] base, logic [31:0] ex);
      logic [31:0] prod;
      prod = 32'd1;
      if (ex[31]) begin
        if (base == 32'd1) return 32'd1;
        if (base == '1) return ex[0] ? '1 : 32'd1;
        return '0;
      end
      while (ex != '0) begin
        if (ex[0]) prod = prod * base;
        base = base * base;
        ex   = ex >> 1;
      end
      return prod;
    endfunction

    function void fail_with(pfe_status_e st, bit at_nul);
      clear_expr();
      skipping = !at_nul;
      expected_q.push_back('{value: 32'h0, status: st});
    endfunction

    // returns 0 for a skipped byte or a stray one (after any pending number is pushed)
    function bit note_input(logic [7:0] ch);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] r;
      if (skipping) begin
        if (ch == CH_NUL) begin
          clear_expr();
          skipping = 1'b0;
          return 1'b1;
        end
        return 1'b0;
      end
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        accum     = accum * 32'd10 + 32'(ch - CH_ZERO);
        in_digits = 1'b1;
        return 1'b1;
      end
      if (in_digits) begin
        if (depth >= STACK_DEPTH_DEF) begin
          fail_with(STAT_OVERFLOW, ch == CH_NUL);
          return 1'b1;
        end
        operands[depth] = accum;
        depth++;
        accum     = '0;
        in_digits = 1'b0;
      end
      if (ch == CH_NUL) begin
        if (depth == 0) begin
          fail_with(STAT_UNDERFLOW, 1'b1);
        end else begin
          expected_q.push_back('{value: operands[depth-1], status: STAT_OK});
          clear_expr();
        end
        return 1'b1;
      end
      if (!(ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET})) return 1'b0;
      if (depth < 2) begin
        fail_with(STAT_UNDERFLOW, 1'b0);
        return 1'b1;
      end
      a = operands[depth-1];
      b = operands[depth-2];
      case (ch)
        CH_PLUS:  r = b + a;
        CH_MINUS: r = b - a;
        CH_STAR:  r = b * a;
        CH_SLASH: begin
          if (a == '0) begin
            fail_with(STAT_DIVZERO, 1'b0);
            return 1'b1;
          end
          r = quotient(b, a);
        end
        default:  r = power(b, a);
      endcase
      depth--;
      operands[depth-1] = r;
      return 1'b1;
    endfunction

    task report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [31:0] value, logic [1:0] status);
      eval_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result value %0h status %0d", value, status));
        return;
      end
      want = expected_q.pop_front();
      if (status !== want.status)
        report($sformatf("status %0d, expected %0d", status, want.status));
      if (value !== want.value)
        report($sformatf("value %0h, expected %0h", value, want.value));
    endtask
  endclass

  eval_scoreboard sb = new();

  postfix_expression_evaluator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // ---------------- text generation ----------------
  function automatic bit is_op(logic [7:0] c);
    return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      default: return CH_CARET;
    endcase
  endfunction

  function automatic logic [7:0] other_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while ((c >= CH_ZERO && c <= CH_NINE) || is_op(c));
    return c;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endfunction

  function automatic void push_sep();
    if ($urandom_range(0, 6) == 0) byte_q.push_back(other_byte());
    else byte_q.push_back(CH_SPACE);
  endfunction

  function automatic logic [31:0] random_operand();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 35) return $urandom_range(0, 9);
    if (k < 55) return $urandom_range(10, 1000);
    if (k < 70) begin
      case ($urandom_range(0, 5))
        0:       return 32'h0;
        1:       return 32'h1;
        2:       return 32'h7FFF_FFFF;
        3:       return 32'h8000_0000;
        4:       return 32'hFFFF_FFFF;
        default: return 32'hFFFF_FFFE;
      endcase
    end
    return $urandom();
  endfunction

  // pushes one operand; a negative one goes in as "0 v -"
  function automatic void emit_value(logic [31:0] v, bit neg);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (neg) begin
      byte_q.push_back(CH_ZERO);
      push_sep();
    end
    if (r < 8) begin
      // long run, wraps the accumulator
      repeat ($urandom_range(11, 14)) byte_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end else begin
      if (r < 16) push_text("00");
      push_text($sformatf("%0d", v));
    end
    push_sep();
    if (neg) begin
      byte_q.push_back(CH_MINUS);
      push_sep();
    end
  endfunction

  function automatic void build_expression();
    int unsigned kind;
    int          pushes_left;
    int          count;
    bit          leave_rest;
    int          n;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      pushes_left = $urandom_range(1, 7);
      count       = 0;
      leave_rest  = ($urandom_range(0, 9) == 0);
      while (pushes_left > 0 || (count > 1 && !leave_rest)) begin
        if (count >= 2 && (pushes_left == 0 || $urandom_range(0, 1) == 1)) begin
          byte_q.push_back(pick_op());
          count--;
        end else begin
          emit_value(random_operand(), $urandom_range(0, 99) < 15);
          pushes_left--;
          count++;
        end
      end
    end else if (kind < 73) begin
      // power corners: bases 0, +-1, 2 against negative, zero and wide exponents
      case ($urandom_range(0, 4))
        0:       emit_value(32'd1, 1'b0);
        1:       emit_value(32'd1, 1'b1);
        2:       emit_value(32'd0, 1'b0);
        3:       emit_value(32'd2, 1'b0);
        default: emit_value(random_operand(), 1'b0);
      endcase
      case ($urandom_range(0, 4))
        0:       emit_value($urandom_range(1, 6), 1'b1);
        1:       emit_value(32'h8000_0000 | $urandom(), 1'b0);
        2:       emit_value(32'd0, 1'b0);
        3:       emit_value($urandom_range(30, 33), 1'b0);
        default: emit_value($urandom(), 1'b0);
      endcase
      byte_q.push_back(CH_CARET);
    end else if (kind < 77) begin
      // fill the stack to around its depth; the last number may end at the NUL
      n = $urandom_range(62, 66);
      for (int i = 0; i < n; i++) begin
        push_text($sformatf("%0d", $urandom_range(0, 99)));
        if (i != n - 1 || $urandom_range(0, 1) == 1) push_sep();
      end
      if ($urandom_range(0, 1) == 1) byte_q.push_back(pick_op());
    end else if (kind < 92) begin
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 3))
          0:       push_text($sformatf("%0d", random_operand()));
          1:       byte_q.push_back(pick_op());
          2:       byte_q.push_back(CH_SPACE);
          default: byte_q.push_back(other_byte());
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 8)) byte_q.push_back(8'($urandom_range(0, 255)));
    end
    byte_q.push_back(CH_NUL);
  endfunction

  // ---------------- driving ----------------
  task automatic send_byte(input logic [7:0] ch);
    int gap;
    gap = sender_burst ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    void'(sb.note_input(ch));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic send_queue(inout int unsigned sent_cnt);
    while (byte_q.size() != 0) begin
      send_byte(byte_q.pop_front());
      sent_cnt++;
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int run;
    int stall;
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        run   = $urandom_range(1, 20);
        stall = ($urandom_range(0, 4) == 0) ? 0 : pick_gap();
        m_axis_tready <= 1'b1;
        repeat (run) @(posedge clk_i);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    int unsigned sent_cnt;
    bit          held;
    bit          drained;
    sent_cnt = 0;
    held     = 1'b0;
    drained  = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty expression, every operator, a stray byte ending a digit
    // run with a leftover operand, underflow followed by discard, divide by zero
    byte_q.push_back(CH_NUL);
    push_text("7 2-3*4/2^");
    byte_q.push_back(CH_NUL);
    push_text("3");
    byte_q.push_back(8'hFF);
    push_text("5");
    byte_q.push_back(CH_NUL);
    push_text("+");
    byte_q.push_back(CH_NUL);
    push_text("4 0/");
    byte_q.push_back(CH_NUL);
    send_queue(sent_cnt);

    while (sent_cnt < N_ITEMS) begin
      sender_burst = ($urandom_range(0, 3) == 0);
      build_expression();
      send_queue(sent_cnt);
      if (!held && sent_cnt >= 300) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (!drained && sent_cnt >= 700) begin
        drain_results();
        drained = 1'b1;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("ERROR: timeout");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hdl/pfe_pkg.sv
hdl/pfe_alu.sv
hdl/postfix_expression_evaluator.sv
hdl/pfe_checker.sv
tb/sv/tb_postfix_expression_evaluator.sv
